// ===== rtl/core/linear_sieve_totient_table_macros.svh =====
// Assertion macros used by the sieve table top level.
`ifndef LINEAR_SIEVE_TOTIENT_TABLE_MACROS_SVH
`define LINEAR_SIEVE_TOTIENT_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LSTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sieve table assertion failed");

// Next-cycle implication, checked outside reset.
`define LSTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sieve table assertion failed");

`else

`define LSTT_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSTT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/lstt_pkg.sv =====
// Constants and codes of the linear sieve totient table.
`default_nettype none

package lstt_pkg;

   // Fixed field widths
   localparam int LIMIT_W   = 12;
   localparam int IDX_W     = 12;
   localparam int VAL_W     = 12;
   localparam int CNT_OUT_W = 11;

   // Request codes
   localparam logic REQ_BUILD = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Status codes
   localparam logic ST_OK  = 1'b0;
   localparam logic ST_ERR = 1'b1;

   // Register port
   localparam int                  CSR_ADDR_W     = 2;
   localparam int                  CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT_ADDR = 2'd0;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 12'd4095;

endpackage

`default_nettype wire

// ===== rtl/core/lstt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lstt_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/linear_sieve_totient_table.sv =====
// Top level of the linear sieve totient and smallest-factor table.
// Usage:
//   Requests come in on req_valid/req_ready with req_type and req_entry_index;
//   each request gives exactly one item on rsp_valid/rsp_ready.
//   A build (req_type 0) clears entries 0..L, L = min(table_limit, MAX_N), then
//   runs the linear sieve over 2..L and reports the prime count.
//   A read (req_type 1) returns phi and smallest prime factor of the index, or
//   status 1 when the index is above the built limit or nothing is built.
//   A read, good or bad, reads the table entry when it is accepted, then loads
//   its result in the finish state once the output register is free.
//   A build clears entries 0..L, then for each integer 2..L reads and checks its
//   entry, then for each multiple tried (each composite written and each product
//   past L) reads the prime, forms the products and writes the composite.
//   One request is worked on at a time; a new one is accepted while the last
//   item still waits in the output register.
//   table_limit is written over the APB-style port at byte address 0.
//   Reset: nothing is built, prime count 0, table_limit 4095. The tables need
//   no clearing pass at reset; each build clears the range it covers.
//   A stalled receiver holds the finished item in the output register and the
//   next request's work waits before its result is loaded.
`default_nettype none
`include "linear_sieve_totient_table_macros.svh"

module linear_sieve_totient_table
   import lstt_pkg::*;
#(
   parameter int MAX_N       = 4095,
   parameter int PRIME_SLOTS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_type,
   input  wire logic [IDX_W-1:0]      req_entry_index,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [VAL_W-1:0]      rsp_totient_value,
   output logic      [VAL_W-1:0]      rsp_smallest_factor,
   output logic      [CNT_OUT_W-1:0]  rsp_primes_found,
   output logic                       rsp_status,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int AW = $clog2(MAX_N + 1);
   localparam int PW = $clog2(PRIME_SLOTS);
   localparam int CW = $clog2(PRIME_SLOTS + 1);
   localparam int XW = (AW > LIMIT_W) ? AW : LIMIT_W;
   localparam int MW = 2 * AW;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_RDI  = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_RDP  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_WR   = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;

   // control registers
   logic [3:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] table_limit_ff, table_limit_in;
   logic [AW-1:0]      lim_ff, lim_in;
   logic [AW-1:0]      built_ff, built_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic [AW-1:0]        fac_i_ff, fac_i_in;
   logic [AW-1:0]        tot_i_ff, tot_i_in;
   logic [AW-1:0]        p_ff, p_in;
   logic [MW-1:0]        prod_ff, prod_in;
   logic [MW-1:0]        tp_ff, tp_in;
   logic                 hit_ff, hit_in;
   logic                 kind_ff, kind_in;
   logic                 bad_ff, bad_in;
   logic [VAL_W-1:0]     rsp_tot_ff, rsp_tot_in;
   logic [VAL_W-1:0]     rsp_fac_ff, rsp_fac_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_st_ff, rsp_st_in;

   // memory ports
   logic          tbl_we, tbl_re;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   logic [AW-1:0] tot_wdata, fac_wdata, tot_rdata, fac_rdata;
   logic [MW-1:0] tbl_rdata;
   logic          pl_we, pl_re;
   logic [PW-1:0] pl_waddr, pl_raddr;
   logic [AW-1:0] pl_wdata, pl_rdata;

   logic          req_fire, csr_write, out_free;
   logic [AW-1:0] lim_sat, p_mul;

   // smallest factor in the upper half of each entry, totient in the lower half
   lstt_ram #(.WIDTH(MW), .DEPTH(MAX_N + 1)) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data ({fac_wdata, tot_wdata}),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign fac_rdata = tbl_rdata[MW-1:AW];
   assign tot_rdata = tbl_rdata[AW-1:0];

   lstt_ram #(.WIDTH(AW), .DEPTH(PRIME_SLOTS)) u_prime_ram (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_waddr),
      .wr_data (pl_wdata),
      .rd_en   (pl_re),
      .rd_addr (pl_raddr),
      .rd_data (pl_rdata)
   );

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == CSR_LIMIT_ADDR);
   assign prdata    = (paddr == CSR_LIMIT_ADDR) ? CSR_DATA_W'(table_limit_ff) : '0;

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // build limit saturates at MAX_N, the last table entry
   assign lim_sat = (XW'(table_limit_ff) > XW'(MAX_N)) ? AW'(MAX_N) : AW'(table_limit_ff);
   // multiplier for phi: p when p divides i, else p - 1
   assign p_mul   = (pl_rdata == fac_i_ff) ? pl_rdata : pl_rdata - AW'(1);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      table_limit_in = csr_write ? LIMIT_W'(pwdata) : table_limit_ff;
      lim_in         = lim_ff;
      built_in       = built_ff;
      cnt_in         = cnt_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      fac_i_in       = fac_i_ff;
      tot_i_in       = tot_i_ff;
      p_in           = p_ff;
      prod_in        = prod_ff;
      tp_in          = tp_ff;
      hit_in         = hit_ff;
      kind_in        = kind_ff;
      bad_in         = bad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_tot_in     = rsp_tot_ff;
      rsp_fac_in     = rsp_fac_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_st_in      = rsp_st_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = i_ff;
      tot_wdata      = '0;
      fac_wdata      = '0;
      tbl_re         = 1'b0;
      tbl_raddr      = i_ff;
      pl_we          = 1'b0;
      pl_waddr       = cnt_ff[PW-1:0];
      pl_wdata       = i_ff;
      pl_re          = 1'b0;
      pl_raddr       = j_ff[PW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in = req_type;
               if (req_type == REQ_READ) begin
                  bad_in    = (built_ff == '0) ||
                              (XW'(req_entry_index) > XW'(built_ff));
                  tbl_re    = 1'b1;
                  tbl_raddr = AW'(req_entry_index);
                  state_in  = S_FIN;
               end else begin
                  bad_in   = ST_OK;
                  lim_in   = lim_sat;
                  built_in = '0;
                  cnt_in   = '0;
                  i_in     = '0;
                  state_in = (lim_sat == '0) ? S_FIN : S_CLR;
               end
            end
         end

         // clear 0..L; entry 1 gets phi 1
         S_CLR: begin
            tbl_we    = 1'b1;
            tot_wdata = (i_ff == AW'(1)) ? AW'(1) : '0;
            if (i_ff == lim_ff) begin
               i_in = AW'(2);
               if (lim_ff == AW'(1)) begin
                  built_in = lim_ff;
                  state_in = S_FIN;
               end else begin
                  state_in = S_RDI;
               end
            end else begin
               i_in = i_ff + AW'(1);
            end
         end

         S_RDI: begin
            tbl_re   = 1'b1;
            state_in = S_CHK;
         end

         // an unmarked entry is prime
         S_CHK: begin
            j_in = '0;
            if (fac_rdata == '0) begin
               tbl_we    = 1'b1;
               fac_wdata = i_ff;
               tot_wdata = i_ff - AW'(1);
               fac_i_in  = i_ff;
               tot_i_in  = i_ff - AW'(1);
               if (cnt_ff < CW'(PRIME_SLOTS)) begin
                  pl_we  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
            end else begin
               fac_i_in = fac_rdata;
               tot_i_in = tot_rdata;
            end
            state_in = S_RDP;
         end

         S_RDP: begin
            if (j_ff < cnt_ff) begin
               pl_re    = 1'b1;
               state_in = S_MUL;
            end else if (i_ff == lim_ff) begin
               built_in = lim_ff;
               state_in = S_FIN;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_RDI;
            end
         end

         S_MUL: begin
            p_in     = pl_rdata;
            hit_in   = (pl_rdata == fac_i_ff);
            prod_in  = MW'(i_ff) * MW'(pl_rdata);
            tp_in    = MW'(tot_i_ff) * MW'(p_mul);
            state_in = S_WR;
         end

         // mark i*p, stop at the limit or at the smallest factor of i
         S_WR: begin
            if (prod_ff > MW'(lim_ff) || hit_ff) begin
               if (prod_ff <= MW'(lim_ff)) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = AW'(prod_ff);
                  fac_wdata = p_ff;
                  tot_wdata = AW'(tp_ff);
               end
               if (i_ff == lim_ff) begin
                  built_in = lim_ff;
                  state_in = S_FIN;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_RDI;
               end
            end else begin
               tbl_we    = 1'b1;
               tbl_waddr = AW'(prod_ff);
               fac_wdata = p_ff;
               tot_wdata = AW'(tp_ff);
               j_in      = j_ff + CW'(1);
               state_in  = S_RDP;
            end
         end

         // load the output register once it is free
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = bad_ff;
               rsp_cnt_in   = CNT_OUT_W'(cnt_ff);
               if (kind_ff == REQ_READ && bad_ff == ST_OK) begin
                  rsp_tot_in = VAL_W'(tot_rdata);
                  rsp_fac_in = VAL_W'(fac_rdata);
               end else begin
                  rsp_tot_in = '0;
                  rsp_fac_in = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         table_limit_ff <= LIMIT_RESET;
         lim_ff         <= '0;
         built_ff       <= '0;
         cnt_ff         <= '0;
         i_ff           <= '0;
         j_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_limit_ff <= table_limit_in;
         lim_ff         <= lim_in;
         built_ff       <= built_in;
         cnt_ff         <= cnt_in;
         i_ff           <= i_in;
         j_ff           <= j_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      fac_i_ff   <= fac_i_in;
      tot_i_ff   <= tot_i_in;
      p_ff       <= p_in;
      prod_ff    <= prod_in;
      tp_ff      <= tp_in;
      hit_ff     <= hit_in;
      kind_ff    <= kind_in;
      bad_ff     <= bad_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_fac_ff <= rsp_fac_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_totient_value   = rsp_tot_ff;
   assign rsp_smallest_factor = rsp_fac_ff;
   assign rsp_primes_found    = rsp_cnt_ff;
   assign rsp_status          = rsp_st_ff;

   // checks
   `LSTT_ASSERT_IMP(a_write_in_range, clock, reset, tbl_we, tbl_waddr <= lim_ff)
   `LSTT_ASSERT_IMP(a_prime_slot_free, clock, reset, pl_we, cnt_ff < CW'(PRIME_SLOTS))
   `LSTT_ASSERT_IMP(a_error_zero, clock, reset, rsp_valid_ff && rsp_st_ff == ST_ERR,
      rsp_tot_ff == '0 && rsp_fac_ff == '0)
   `LSTT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the linear sieve totient table: directed and random requests.
`timescale 1ns / 1ps

module tb
   import lstt_pkg::*;
();

   localparam int MAX_N       = 4095;
   localparam int PRIME_SLOTS = 1024;
   localparam int IDLE_PCT    = 24;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 200000;

   // one expected reply
   typedef struct packed {
      logic [VAL_W-1:0]     totient;
      logic [VAL_W-1:0]     factor;
      logic [CNT_OUT_W-1:0] primes;
      logic                 status;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_BUILD;
   logic [IDX_W-1:0]      req_entry_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VAL_W-1:0]      rsp_totient_value;
   logic [VAL_W-1:0]      rsp_smallest_factor;
   logic [CNT_OUT_W-1:0]  rsp_primes_found;
   logic                  rsp_status;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // bench control
   logic                  no_gaps = 1'b0;
   logic                  hold_req = 1'b0;
   int                    hold_cnt = 0;
   int                    stall_cycles = 0;
   int                    err_count = 0;
   int                    replies_seen = 0;
   int                    build_count = 0;
   int                    read_count = 0;
   int                    reject_count = 0;

   // predictor state
   int unsigned           phi_tab [0:MAX_N];
   int unsigned           spf_tab [0:MAX_N];
   int unsigned           prime_seen [0:PRIME_SLOTS-1];
   int unsigned           prime_cnt;
   int unsigned           built_to;
   logic [LIMIT_W-1:0]    limit_model;
   reply_type             pending_replies[$];

   always #1 clock = ~clock;

   linear_sieve_totient_table #(
      .MAX_N(MAX_N),
      .PRIME_SLOTS(PRIME_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_totient_value(rsp_totient_value),
      .rsp_smallest_factor(rsp_smallest_factor),
      .rsp_primes_found(rsp_primes_found),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   task automatic report_error(string msg);
      err_count++;
      $display("MISMATCH: %s", msg);
   endtask

   // Euler sieve over 2..lim; each composite is written once, by its smallest prime
   function automatic void sieve_rebuild(int unsigned lim);
      int unsigned i;
      int unsigned j;
      int unsigned p;
      int unsigned prod;
      for (int k = 0; k <= MAX_N; k++) begin
         phi_tab[k] = 0;
         spf_tab[k] = 0;
      end
      prime_cnt = 0;
      built_to = 0;
      if (lim > MAX_N) lim = MAX_N;
      if (lim == 0) return;
      phi_tab[1] = 1;
      for (i = 2; i <= lim; i++) begin
         if (spf_tab[i] == 0) begin
            spf_tab[i] = i;
            phi_tab[i] = i - 1;
            // a full prime list drops further primes as multipliers
            if (prime_cnt < PRIME_SLOTS) begin
               prime_seen[prime_cnt] = i;
               prime_cnt++;
            end
         end
         for (j = 0; j < prime_cnt; j++) begin
            p = prime_seen[j];
            prod = i * p;
            if (prod > lim) break;
            spf_tab[prod] = p;
            if (p == spf_tab[i]) begin
               phi_tab[prod] = phi_tab[i] * p;
               break;
            end
            phi_tab[prod] = phi_tab[i] * (p - 1);
         end
      end
      built_to = lim;
   endfunction

   // expected reply for one request, updating the tables on a build
   function automatic reply_type predict_reply(logic kind, logic [IDX_W-1:0] idx);
      reply_type r;
      r = '0;
      r.status = ST_OK;
      if (kind == REQ_BUILD) begin
         sieve_rebuild(limit_model);
      end else if (built_to == 0 || idx > built_to) begin
         r.status = ST_ERR;
      end else begin
         r.totient = phi_tab[idx][VAL_W-1:0];
         r.factor  = spf_tab[idx][VAL_W-1:0];
      end
      r.primes = prime_cnt[CNT_OUT_W-1:0];
      return r;
   endfunction

   // offer one item and hold it until accepted
   task automatic send_request(logic kind, logic [IDX_W-1:0] idx);
      reply_type r;
      req_valid <= 1'b1;
      req_type <= kind;
      req_entry_index <= idx;
      do @(posedge clock); while (!req_ready);
      r = predict_reply(kind, idx);
      pending_replies.push_back(r);
      if (kind == REQ_BUILD) build_count++;
      else read_count++;
      if (kind == REQ_READ && r.status == ST_ERR) reject_count++;
      if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // one register access: setup then access phase; reads are compared
   task automatic csr_access(logic wr, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CSR_LIMIT_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      if (wr) limit_model = value[LIMIT_W-1:0];
      else if (prdata[LIMIT_W-1:0] !== limit_model)
         report_error($sformatf("table_limit read %0d, expected %0d",
                                prdata[LIMIT_W-1:0], limit_model));
      @(posedge clock);
   endtask

   task automatic set_limit(logic [CSR_DATA_W-1:0] value);
      wait_quiet();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   // reads with nothing built, plus the reset value of the limit
   task automatic test_before_build();
      csr_access(1'b0, '0);
      send_request(REQ_READ, '0);
      send_request(REQ_READ, 12'd1);
      send_request(REQ_READ, '1);
   endtask

   // build at the reset limit, probe both ends of the table
   task automatic test_full_build();
      send_request(REQ_BUILD, '1);
      send_request(REQ_READ, '0);
      send_request(REQ_READ, 12'd1);
      send_request(REQ_READ, 12'd2);
      send_request(REQ_READ, 12'd4);
      send_request(REQ_READ, 12'd2048);
      send_request(REQ_READ, 12'd4093);
      send_request(REQ_READ, 12'd4094);
      send_request(REQ_READ, '1);
   endtask

   // limit one, limit zero (upper data bits set), limit two
   task automatic test_limit_extremes();
      set_limit(32'd1);
      send_request(REQ_BUILD, '0);
      send_request(REQ_READ, '0);
      send_request(REQ_READ, 12'd1);
      send_request(REQ_READ, 12'd2);
      set_limit(32'hFFFF_F000);
      send_request(REQ_BUILD, 12'd5);
      send_request(REQ_READ, '0);
      send_request(REQ_READ, 12'd1);
      set_limit(32'd2);
      send_request(REQ_BUILD, '0);
      send_request(REQ_READ, 12'd2);
      send_request(REQ_READ, 12'd3);
   endtask

   // receiver stalls while reads keep coming, so the input backs up
   task automatic test_pressure();
      set_limit(32'd97);
      send_request(REQ_BUILD, '0);
      wait_quiet();
      no_gaps <= 1'b1;
      hold_req <= 1'b1;
      fork
         begin
            for (int n = 0; n < 12; n++)
               send_request(REQ_READ, 12'($urandom_range(0, 120)));
         end
         begin
            wait (hold_cnt == HOLD_CYCLES);
            @(posedge clock);
            hold_req <= 1'b0;
         end
      join
      no_gaps <= 1'b0;
   endtask

   // phases of one limit each: mostly build then reads around the built range
   task automatic test_random_mix();
      logic [CSR_DATA_W-1:0] wv;
      int unsigned           lim;
      int unsigned           roll;
      int unsigned           pick;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: lim = $urandom_range(2, 40);
            1: lim = $urandom_range(41, 400);
            2: lim = $urandom_range(1, 150);
            3: lim = $urandom_range(3000, MAX_N);
            default: lim = $urandom_range(1, 700);
         endcase
         wv = $urandom;
         wv[LIMIT_W-1:0] = lim[LIMIT_W-1:0];
         set_limit(wv);
         no_gaps <= (ph == 2);
         for (int n = 0; n < 15; n++) begin
            roll = $urandom_range(99);
            if ((n == 0 && roll < 80) || (n > 0 && roll < 8)) begin
               send_request(REQ_BUILD, 12'($urandom));
            end else begin
               roll = $urandom_range(99);
               if (built_to != 0 && roll < 60) begin
                  pick = $urandom_range(0, built_to);
               end else if (roll < 85) begin
                  pick = built_to + $urandom_range(1, 8);
                  if (pick > MAX_N) pick = MAX_N;
               end else begin
                  pick = $urandom;
               end
               send_request(REQ_READ, pick[IDX_W-1:0]);
            end
         end
      end
      no_gaps <= 1'b0;
   endtask

   // receiver: random stalls, a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
         if (!hold_req) hold_cnt <= 0;
      end
   end

   // compare each accepted reply with the oldest expected one
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_error($sformatf("reply %0d with nothing pending", replies_seen));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_totient_value !== want.totient)
               report_error($sformatf("reply %0d totient_value %0d, expected %0d",
                                      replies_seen, rsp_totient_value, want.totient));
            if (rsp_smallest_factor !== want.factor)
               report_error($sformatf("reply %0d smallest_factor %0d, expected %0d",
                                      replies_seen, rsp_smallest_factor, want.factor));
            if (rsp_primes_found !== want.primes)
               report_error($sformatf("reply %0d primes_found %0d, expected %0d",
                                      replies_seen, rsp_primes_found, want.primes));
            if (rsp_status !== want.status)
               report_error($sformatf("reply %0d status %0b, expected %0b",
                                      replies_seen, rsp_status, want.status));
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("linear_sieve_totient_table test failed");
         $finish;
      end
   end

   initial begin
      sieve_rebuild(0);
      limit_model = LIMIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_build();
      test_full_build();
      test_limit_extremes();
      test_pressure();
      test_random_mix();
      wait_quiet();
      repeat (16) @(posedge clock);
      $display("Ran %0d builds and %0d reads (%0d out of range), %0d replies checked.",
               build_count, read_count, reject_count, replies_seen);
      $display("Limits 0 through 4095, %0d-cycle receiver hold-off, random idling.",
               HOLD_CYCLES);
      if (err_count == 0)
         $display("linear_sieve_totient_table test passed");
      else
         $display("linear_sieve_totient_table test failed");
      $finish;
   end

endmodule
